// ===== rtl/dlf_pkg.sv =====
package dlf_pkg;

  // Request codes carried by an input item
  typedef enum logic [1:0] {
    REQ_ELEM   = 2'd0,
    REQ_WEIGHT = 2'd1,
    REQ_BIAS   = 2'd2
  } req_e;

  // Activation select codes
  typedef enum logic [1:0] {
    ACT_NONE = 2'd0,
    ACT_RELU = 2'd1,
    ACT_SIG  = 2'd2
  } act_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_ACT     = 2'd0,
    CFG_IN_CNT  = 2'd1,
    CFG_OUT_CNT = 2'd2
  } cfg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WAIT,
    ST_DRAIN
  } state_e;

  localparam int CNT_W = 6;
  localparam int ACC_W = 40;
  localparam int SUM_W = 41;

  localparam logic [1:0] ACT_RESET     = 2'd1;
  localparam logic [CNT_W-1:0] CNT_RESET = 6'd32;

  // Input item
  typedef struct packed {
    logic [1:0]         req_type;
    logic [4:0]         row_index;
    logic [4:0]         col_index;
    logic signed [15:0] in_value;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic [4:0]         out_index;
    logic signed [15:0] out_value;
    logic               out_saturated;
    logic               out_last;
  } out_item_t;

  // Token that walks down the cell chain
  typedef struct packed {
    logic               vld;
    logic               elem;
    logic               wt;
    logic               bias;
    logic               last;
    logic [4:0]         row;
    logic [4:0]         col;
    logic signed [15:0] value;
  } tok_t;

  // Control broadcast to every cell
  typedef struct packed {
    logic             load;
    logic             shift;
    logic [CNT_W-1:0] nout;
  } cell_ctl_t;

  // Sigmoid table: entry i = round(256*sigmoid((i-128)/16))
  localparam logic [31:0] EXP_STEP_Q32 = 32'd4034748382;
  localparam logic [32:0] ONE_Q32      = 33'h1_0000_0000;

  typedef logic [255:0][8:0] sig_lut_t;

  function automatic sig_lut_t sig_build();
    logic [32:0] e [129];
    logic [95:0] p;
    logic [32:0] ev;
    logic [32:0] num;
    logic [33:0] den;
    logic [47:0] n;
    logic [47:0] dd;
    logic [8:0]  q;
    sig_lut_t    t;
    int          k;
    int          d;
    int          b;
    e[0] = ONE_Q32;
    // exp(-k/16) in Q32, each step rounded to nearest
    for (k = 1; k <= 128; k++) begin
      p    = 96'(e[k-1]) * 96'(EXP_STEP_Q32) + 96'h8000_0000;
      e[k] = p[64:32];
    end
    for (k = 0; k < 256; k++) begin
      d   = k - 128;
      ev  = e[(d < 0) ? -d : d];
      den = 34'(ONE_Q32) + 34'(ev);
      num = (d < 0) ? ev : ONE_Q32;
      n   = (48'(num) << 9) + 48'(den);
      dd  = 48'(den) << 1;
      q   = '0;
      // restoring long division, quotient fits in 9 bits
      for (b = 8; b >= 0; b--) begin
        if (n >= (dd << b)) begin
          n    = n - (dd << b);
          q[b] = 1'b1;
        end
      end
      t[k] = q;
    end
    return t;
  endfunction

  localparam sig_lut_t SIG_LUT = sig_build();

endpackage

// ===== rtl/dense_layer_forward.sv =====
// Channel  Direction  Handshake           Payload
// cfg      in         cfg_valid_i/ready   cfg_index_i, cfg_data_i
// in       in         in_valid_i/stall    in_item_i  (dlf_pkg::in_item_t)
// out      out        out_valid_o/stall   out_item_o (dlf_pkg::out_item_t)
//
// Weight, bias and non-final element items are taken one per cycle; each rides
// the cell chain one cell per cycle. The final element stalls input until its
// results are out: it crosses the chain, then the results drain from cell 0,
// one per cycle while the output is not stalled, out_count results in all.
// A stalled result holds in the output register. Reset clears the
// accumulators and control; weights and biases hold nothing until written.
module dense_layer_forward #(
  parameter int IN_MAX  = 32,
  parameter int OUT_MAX = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [1:0]           cfg_index_i,
  input  logic [5:0]           cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  dlf_pkg::in_item_t    in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output dlf_pkg::out_item_t   out_item_o
);

  logic [1:0]                act_q;
  logic [dlf_pkg::CNT_W-1:0] in_cnt_q;
  logic [dlf_pkg::CNT_W-1:0] out_cnt_q;
  logic [dlf_pkg::CNT_W-1:0] nin;
  logic [dlf_pkg::CNT_W-1:0] nout;
  logic [dlf_pkg::CNT_W-1:0] cnt_q, cnt_d;
  dlf_pkg::state_e           state_q, state_d;
  dlf_pkg::cell_ctl_t        ctl;
  dlf_pkg::tok_t             tk [OUT_MAX+1];
  logic [dlf_pkg::SUM_W-1:0] sh [OUT_MAX+1];
  logic                      last_d1_q;
  logic                      done_q;
  logic                      out_valid_q, out_valid_d;
  dlf_pkg::out_item_t        out_item_q, out_item_d;
  logic                      take;
  logic signed [15:0]        act_value;
  logic                      act_sat;
  logic                      in_go;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q     <= dlf_pkg::ACT_RESET;
      in_cnt_q  <= dlf_pkg::CNT_RESET;
      out_cnt_q <= dlf_pkg::CNT_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        dlf_pkg::CFG_ACT:     act_q     <= cfg_data_i[1:0];
        dlf_pkg::CFG_IN_CNT:  in_cnt_q  <= cfg_data_i;
        dlf_pkg::CFG_OUT_CNT: out_cnt_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clamp counts to 1..max
  always_comb begin
    if (in_cnt_q == '0) begin
      nin = dlf_pkg::CNT_W'(1);
    end else if (int'(in_cnt_q) > IN_MAX) begin
      nin = dlf_pkg::CNT_W'(IN_MAX);
    end else begin
      nin = in_cnt_q;
    end
    if (out_cnt_q == '0) begin
      nout = dlf_pkg::CNT_W'(1);
    end else if (int'(out_cnt_q) > OUT_MAX) begin
      nout = dlf_pkg::CNT_W'(OUT_MAX);
    end else begin
      nout = out_cnt_q;
    end
  end

  // Build the token for an accepted item
  assign in_stall_o = state_q != dlf_pkg::ST_IDLE;
  assign in_go      = in_valid_i && !in_stall_o;

  always_comb begin
    tk[0].vld   = in_go;
    tk[0].elem  = (in_item_i.req_type == dlf_pkg::REQ_ELEM) &&
                  ({1'b0, in_item_i.col_index} < nin);
    tk[0].wt    = in_item_i.req_type == dlf_pkg::REQ_WEIGHT;
    tk[0].bias  = in_item_i.req_type == dlf_pkg::REQ_BIAS;
    tk[0].last  = {1'b0, in_item_i.col_index} == (nin - dlf_pkg::CNT_W'(1));
    tk[0].row   = in_item_i.row_index;
    tk[0].col   = in_item_i.col_index;
    tk[0].value = in_item_i.in_value;
  end

  // Chain of row cells
  assign sh[OUT_MAX] = '0;

  for (genvar r = 0; r < OUT_MAX; r++) begin : g_cell
    dlf_cell #(
      .ROW    (r),
      .IN_MAX (IN_MAX)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .tk_i   (tk[r]),
      .tk_o   (tk[r+1]),
      .ctl_i  (ctl),
      .sh_i   (sh[r+1]),
      .sh_o   (sh[r])
    );
  end

  // Final element leaves the chain; last_d1_q and done_q wait while the last cell accumulates
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_d1_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      last_d1_q <= tk[OUT_MAX].vld && tk[OUT_MAX].elem && tk[OUT_MAX].last;
      done_q    <= last_d1_q;
    end
  end

  dlf_act u_act (
    .sum_i      (sh[0]),
    .act_mode_i (act_q),
    .value_o    (act_value),
    .sat_o      (act_sat)
  );

  // Sequencer: wait for the wave, snapshot sums, drain results
  assign take = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    ctl.load    = 1'b0;
    ctl.shift   = 1'b0;
    ctl.nout    = nout;
    out_valid_d = out_valid_q && out_stall_i;
    out_item_d  = out_item_q;
    unique case (state_q)
      dlf_pkg::ST_IDLE: begin
        if (tk[0].vld && tk[0].elem && tk[0].last) begin
          state_d = dlf_pkg::ST_WAIT;
        end
      end
      dlf_pkg::ST_WAIT: begin
        if (done_q) begin
          ctl.load = 1'b1;
          cnt_d    = '0;
          state_d  = dlf_pkg::ST_DRAIN;
        end
      end
      dlf_pkg::ST_DRAIN: begin
        if (take) begin
          ctl.shift                = 1'b1;
          out_valid_d              = 1'b1;
          out_item_d.out_index     = cnt_q[4:0];
          out_item_d.out_value     = act_value;
          out_item_d.out_saturated = act_sat;
          out_item_d.out_last      = cnt_q == (nout - dlf_pkg::CNT_W'(1));
          if (cnt_q == (nout - dlf_pkg::CNT_W'(1))) begin
            cnt_d   = '0;
            state_d = dlf_pkg::ST_IDLE;
          end else begin
            cnt_d = cnt_q + dlf_pkg::CNT_W'(1);
          end
        end
      end
      default: state_d = dlf_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dlf_pkg::ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// ===== rtl/dlf_cell.sv =====
module dlf_cell #(
  parameter int ROW    = 0,
  parameter int IN_MAX = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  dlf_pkg::tok_t               tk_i,
  output dlf_pkg::tok_t               tk_o,
  input  dlf_pkg::cell_ctl_t          ctl_i,
  input  logic [dlf_pkg::SUM_W-1:0]   sh_i,
  output logic [dlf_pkg::SUM_W-1:0]   sh_o
);

  localparam int IW = (IN_MAX > 1) ? $clog2(IN_MAX) : 1;
  localparam int CW = IW + 5;

  logic [15:0]              wmem_q [IN_MAX];
  logic signed [15:0]       rd_q;
  logic signed [15:0]       bias_q;
  dlf_pkg::tok_t            a_q;
  logic signed [31:0]       prod_q;
  logic                     pv_q;
  logic [dlf_pkg::ACC_W-1:0] acc_q;
  logic [dlf_pkg::SUM_W-1:0] sh_q;
  logic [dlf_pkg::SUM_W-1:0] sum;
  logic [CW-1:0]            col_ext;
  logic [IW-1:0]            addr;
  logic                     hit_row;
  logic                     col_ok;
  logic                     row_en;

  assign col_ext = CW'(tk_i.col);
  assign addr    = col_ext[IW-1:0];
  assign col_ok  = col_ext < CW'(IN_MAX);
  assign hit_row = {1'b0, tk_i.row} == dlf_pkg::CNT_W'(ROW);
  assign row_en  = dlf_pkg::CNT_W'(ROW) < ctl_i.nout;

  // Weight column of this row: write on weight token, read on element token
  always_ff @(posedge clk_i) begin
    if (tk_i.vld && tk_i.wt && hit_row && col_ok) begin
      wmem_q[addr] <= tk_i.value;
    end
    if (tk_i.vld && tk_i.elem) begin
      rd_q <= wmem_q[addr];
    end
    if (tk_i.vld && tk_i.bias && hit_row) begin
      bias_q <= tk_i.value;
    end
  end

  // Register the token, then hand it to the next cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q  <= '0;
      pv_q <= 1'b0;
    end else begin
      a_q  <= tk_i;
      pv_q <= a_q.vld && a_q.elem && row_en;
    end
  end

  assign tk_o = a_q;

  // Multiply weight by element
  always_ff @(posedge clk_i) begin
    if (a_q.vld && a_q.elem) begin
      prod_q <= rd_q * a_q.value;
    end
  end

  // Accumulate; clear on load
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (ctl_i.load) begin
      acc_q <= '0;
    end else if (pv_q) begin
      acc_q <= acc_q + {{8{prod_q[31]}}, prod_q};
    end
  end

  assign sum = {acc_q[dlf_pkg::ACC_W-1], acc_q} + {{17{bias_q[15]}}, bias_q, 8'b0};

  // Result shift line toward cell zero
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      sh_q <= sum;
    end else if (ctl_i.shift) begin
      sh_q <= sh_i;
    end
  end

  assign sh_o = sh_q;

endmodule

// ===== rtl/dlf_act.sv =====
module dlf_act (
  input  logic [dlf_pkg::SUM_W-1:0] sum_i,
  input  logic [1:0]                act_mode_i,
  output logic signed [15:0]        value_o,
  output logic                      sat_o
);

  logic [32:0]        z;
  logic               sat_hi;
  logic               sat_lo;
  logic signed [15:0] z16;
  logic               clip_lo;
  logic               clip_hi;
  logic [7:0]         idx;

  // Floor divide by 256 and saturate to 16 bits
  assign z      = sum_i[dlf_pkg::SUM_W-1:8];
  assign sat_hi = !z[32] && (|z[31:15]);
  assign sat_lo = z[32] && !(&z[31:15]);
  assign sat_o  = sat_hi || sat_lo;

  always_comb begin
    if (sat_hi) begin
      z16 = 16'sh7fff;
    end else if (sat_lo) begin
      z16 = 16'sh8000;
    end else begin
      z16 = z[15:0];
    end
  end

  // Clamp to plus or minus 8.0 and index the sigmoid table
  assign clip_lo = z16[15] && !(&z16[14:11]);
  assign clip_hi = !z16[15] && (|z16[14:11]);

  always_comb begin
    if (clip_lo) begin
      idx = 8'd0;
    end else if (clip_hi) begin
      idx = 8'd255;
    end else begin
      idx = {~z16[11], z16[10:4]};
    end
  end

  always_comb begin
    case (act_mode_i)
      dlf_pkg::ACT_RELU: value_o = z16[15] ? 16'sd0 : z16;
      dlf_pkg::ACT_SIG:  value_o = 16'(dlf_pkg::SIG_LUT[idx]);
      default:           value_o = z16;
    endcase
  end

endmodule

// ===== rtl/dlf_chk.sv =====
module dlf_chk (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_stall_i,
  input logic               out_valid_i,
  input logic               out_stall_i,
  input dlf_pkg::out_item_t out_item_i
);

  logic out_acc;

  assign out_acc = out_valid_i && !out_stall_i;

  // A stalled item holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i && $stable(out_item_i))
    else $error("stalled result changed");

  // A non-final result is followed at once by the next one
  a_drain_gapless: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && !out_item_i.out_last |=> out_valid_i)
    else $error("gap inside a result burst");

  // Rows come out in order
  a_row_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && !out_item_i.out_last |=>
      out_item_i.out_index == $past(out_item_i.out_index) + 5'd1)
    else $error("result rows out of order");

  // No input is taken while a burst is still draining
  a_stall_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && !out_item_i.out_last |-> in_stall_i)
    else $error("input taken during result drain");

endmodule

bind dense_layer_forward dlf_chk u_dlf_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_i  (in_stall_o),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_i  (out_item_o)
);

// ===== sim/dense_layer_checker.sv =====
`timescale 1ns / 1ps

module dense_layer_checker #(
  parameter int IN_MAX  = 32,
  parameter int OUT_MAX = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [5:0]         cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  dlf_pkg::in_item_t  in_item_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  dlf_pkg::out_item_t out_item_i,
  output int                 fail_count_o,
  output int                 rows_due_o
);

  logic signed [15:0] weight_mem [OUT_MAX][IN_MAX];
  logic signed [15:0] bias_mem [OUT_MAX];
  logic [39:0]        row_acc [OUT_MAX];
  logic [8:0]         sigmoid_lut [256];
  logic [1:0]         act_sel;
  logic [5:0]         in_cnt;
  logic [5:0]         out_cnt;
  dlf_pkg::out_item_t expected_rows [$];

  // Build the sigmoid table: exp(-k/16) in Q32 by repeated rounded multiplication
  initial begin : build_lut
    logic [32:0] exp_q32 [129];
    logic [95:0] prod;
    logic [63:0] num;
    logic [63:0] den;
    int          k;
    int          mag;
    exp_q32[0] = 33'h1_0000_0000;
    for (k = 1; k <= 128; k++) begin
      prod       = 96'(exp_q32[k-1]) * 96'd4034748382 + 96'h8000_0000;
      exp_q32[k] = prod[64:32];
    end
    for (k = 0; k < 256; k++) begin
      mag = (k < 128) ? 128 - k : k - 128;
      den = 64'h1_0000_0000 + 64'(exp_q32[mag]);
      num = (k < 128) ? 64'(exp_q32[mag]) : 64'h1_0000_0000;
      sigmoid_lut[k] = 9'((512 * num + den) / (2 * den));
    end
  end

  task automatic report(string field, int want, int got);
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    dlf_pkg::out_item_t want;
    logic signed [31:0] prod;
    logic signed [63:0] pre;
    logic               sat;
    int                 nin;
    int                 nout;
    int                 r;
    if (!rst_ni) begin
      act_sel = dlf_pkg::ACT_RESET;
      in_cnt  = dlf_pkg::CNT_RESET;
      out_cnt = dlf_pkg::CNT_RESET;
      for (r = 0; r < OUT_MAX; r++) row_acc[r] = '0;
      expected_rows.delete();
      fail_count_o = 0;
      rows_due_o   = 0;
    end else begin
      // Retire a delivered result against the oldest expectation
      if (out_valid_i && !out_stall_i) begin
        if (expected_rows.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual row %0d value %0d",
                   $time, out_item_i.out_index, out_item_i.out_value);
          fail_count_o++;
        end else begin
          want = expected_rows.pop_front();
          if (out_item_i.out_index !== want.out_index)
            report("out_index", want.out_index, out_item_i.out_index);
          if (out_item_i.out_value !== want.out_value)
            report("out_value", want.out_value, out_item_i.out_value);
          if (out_item_i.out_saturated !== want.out_saturated)
            report("out_saturated", want.out_saturated, out_item_i.out_saturated);
          if (out_item_i.out_last !== want.out_last)
            report("out_last", want.out_last, out_item_i.out_last);
        end
      end

      // Mirror register writes
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          dlf_pkg::CFG_ACT:     act_sel = cfg_data_i[1:0];
          dlf_pkg::CFG_IN_CNT:  in_cnt  = cfg_data_i;
          dlf_pkg::CFG_OUT_CNT: out_cnt = cfg_data_i;
          default: ;
        endcase
      end

      // Apply an accepted item
      if (in_valid_i && !in_stall_i) begin
        nin  = (in_cnt == 0) ? 1 : (in_cnt > IN_MAX) ? IN_MAX : in_cnt;
        nout = (out_cnt == 0) ? 1 : (out_cnt > OUT_MAX) ? OUT_MAX : out_cnt;
        case (in_item_i.req_type)
          dlf_pkg::REQ_WEIGHT: begin
            if (in_item_i.row_index < OUT_MAX && in_item_i.col_index < IN_MAX)
              weight_mem[in_item_i.row_index][in_item_i.col_index] = in_item_i.in_value;
          end
          dlf_pkg::REQ_BIAS: begin
            if (in_item_i.row_index < OUT_MAX)
              bias_mem[in_item_i.row_index] = in_item_i.in_value;
          end
          dlf_pkg::REQ_ELEM: begin
            if (in_item_i.col_index < nin) begin
              for (r = 0; r < nout; r++) begin
                prod       = weight_mem[r][in_item_i.col_index] * in_item_i.in_value;
                row_acc[r] = row_acc[r] + {{8{prod[31]}}, prod};
              end
              // Last column: emit one result per row, then clear the sums
              if (in_item_i.col_index == nin - 1) begin
                for (r = 0; r < nout; r++) begin
                  pre = ($signed({{24{row_acc[r][39]}}, row_acc[r]}) +
                         bias_mem[r] * 64'sd256) >>> 8;
                  sat = 1'b0;
                  if (pre > 32767) begin
                    pre = 32767;
                    sat = 1'b1;
                  end else if (pre < -32768) begin
                    pre = -32768;
                    sat = 1'b1;
                  end
                  case (act_sel)
                    dlf_pkg::ACT_RELU: if (pre < 0) pre = 0;
                    dlf_pkg::ACT_SIG: begin
                      if (pre < -2048) pre = -2048;
                      else if (pre > 2047) pre = 2047;
                      pre = sigmoid_lut[int'((pre + 2048) >>> 4)];
                    end
                    default: ;
                  endcase
                  want.out_index     = r[4:0];
                  want.out_value     = pre[15:0];
                  want.out_saturated = sat;
                  want.out_last      = (r == nout - 1);
                  expected_rows      = {expected_rows, want};
                end
                for (r = 0; r < OUT_MAX; r++) row_acc[r] = '0;
              end
            end
          end
          default: ;
        endcase
      end
      rows_due_o = expected_rows.size();
    end
  end

endmodule

// ===== sim/dense_layer_forward_tb.sv =====
`timescale 1ns / 1ps

module dense_layer_forward_tb;

  localparam int         IN_MAX         = 32;
  localparam int         OUT_MAX        = 32;
  localparam logic [1:0] REQ_UNUSED     = 2'd3;
  localparam logic [1:0] ACT_UNUSED     = 2'd3;
  localparam int         OVERFLOW_ELEMS = 513;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = '0;
  logic [5:0]         cfg_data  = '0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  dlf_pkg::in_item_t  in_item   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  dlf_pkg::out_item_t out_item;
  int                 fail_count;
  int                 rows_due;

  bit                 calm = 1'b0;
  bit                 wt_set [OUT_MAX][IN_MAX];
  bit                 bias_set [OUT_MAX];
  int                 lanes_in  = IN_MAX;
  int                 lanes_out = OUT_MAX;
  int                 counted;
  dlf_pkg::in_item_t  burst [$];

  always #1 clk = ~clk;

  // Random back-pressure on the result side
  always @(negedge clk) out_stall <= !calm && ($urandom_range(99) < 29);

  dense_layer_forward #(
    .IN_MAX (IN_MAX),
    .OUT_MAX(OUT_MAX)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item)
  );

  dense_layer_checker #(
    .IN_MAX (IN_MAX),
    .OUT_MAX(OUT_MAX)
  ) rows_check (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_item_i   (in_item),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_item_i  (out_item),
    .fail_count_o(fail_count),
    .rows_due_o  (rows_due)
  );

  // Hard stop
  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Q8.8 value: extremes, small magnitudes near the sigmoid range, or anything
  function automatic logic signed [15:0] pick_value();
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(5))
          0: return 16'sh8000;
          1: return 16'sh7fff;
          2: return 16'sh0000;
          3: return 16'shffff;
          4: return 16'sh0001;
          default: return 16'sh0100;
        endcase
      end
      1, 2, 3, 4: return 16'($urandom_range(1024) - 512);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic add(logic [1:0] req, int row, int col, logic signed [15:0] val);
    dlf_pkg::in_item_t it;
    it.req_type  = req;
    it.row_index = row[4:0];
    it.col_index = col[4:0];
    it.in_value  = val;
    if (req == dlf_pkg::REQ_WEIGHT) wt_set[row][col] = 1'b1;
    if (req == dlf_pkg::REQ_BIAS) bias_set[row] = 1'b1;
    burst = {burst, it};
  endtask

  task automatic add_elem(int col, logic signed [15:0] val);
    int r;
    if (col < lanes_in) begin
      // Fill every weight this element reads, and the biases ahead of the last one
      for (r = 0; r < lanes_out; r++) begin
        if (!wt_set[r][col]) add(dlf_pkg::REQ_WEIGHT, r, col, pick_value());
        if (col == lanes_in - 1 && !bias_set[r])
          add(dlf_pkg::REQ_BIAS, r, $urandom_range(31), pick_value());
      end
      counted++;
    end
    add(dlf_pkg::REQ_ELEM, $urandom_range(31), col, val);
  endtask

  task automatic add_vector();
    int c;
    for (c = 0; c < lanes_in; c++) begin
      // Now and then drop or repeat an element ahead of the last column
      if (c < lanes_in - 1 && $urandom_range(19) == 0) continue;
      add_elem(c, pick_value());
      if (c < lanes_in - 1 && $urandom_range(19) == 0) add_elem(c, pick_value());
    end
  endtask

  task automatic add_noise();
    case ($urandom_range(4))
      0: begin
        add(dlf_pkg::REQ_WEIGHT, $urandom_range(31), $urandom_range(31), pick_value());
        counted++;
      end
      1: begin
        add(dlf_pkg::REQ_BIAS, $urandom_range(31), $urandom_range(31), pick_value());
        counted++;
      end
      2: add(REQ_UNUSED, $urandom_range(31), $urandom_range(31), pick_value());
      // any column: may be past in_count, or an early last column
      3: add_elem($urandom_range(31), pick_value());
      default: add_elem($urandom_range(lanes_in - 1), pick_value());
    endcase
  endtask

  task automatic play_burst();
    dlf_pkg::in_item_t it;
    while (burst.size() > 0) begin
      it = burst.pop_front();
      while (!calm && $urandom_range(99) < 29) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
      in_valid <= 1'b1;
      in_item  <= it;
      do @(posedge clk); while (in_stall);
      @(negedge clk);
    end
    in_valid <= 1'b0;
  endtask

  // Wait out every pending result, then let queued writes clear the cell chain
  task automatic settle();
    wait (rows_due == 0);
    @(negedge clk);
    repeat (OUT_MAX + 8) @(negedge clk);
  endtask

  task automatic put_reg(logic [1:0] idx, logic [5:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic set_config(logic [1:0] act, logic [5:0] nin, logic [5:0] nout);
    settle();
    put_reg(dlf_pkg::CFG_ACT, {4'd0, act});
    put_reg(dlf_pkg::CFG_IN_CNT, nin);
    put_reg(dlf_pkg::CFG_OUT_CNT, nout);
    cfg_valid <= 1'b0;
    lanes_in  = (nin == 0) ? 1 : (nin > IN_MAX) ? IN_MAX : nin;
    lanes_out = (nout == 0) ? 1 : (nout > OUT_MAX) ? OUT_MAX : nout;
  endtask

  task automatic run_phase(logic [1:0] act, logic [5:0] nin, logic [5:0] nout, int target);
    set_config(act, nin, nout);
    counted = 0;
    while (counted < target) begin
      if ($urandom_range(99) < 70) add_vector();
      else add_noise();
    end
    play_burst();
  endtask

  initial begin : stimulus
    logic signed [15:0] probe [8];
    int                 k;
    probe = '{16'sh8000, 16'shf7ff, 16'shf800, 16'sh07ff,
              16'sh0800, 16'sh7fff, 16'sh0000, 16'shffff};
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Extreme values and indexes, ignored items, repeated and lone last columns
    set_config(dlf_pkg::ACT_NONE, 6'd2, 6'd2);
    add(dlf_pkg::REQ_WEIGHT, 0, 0, 16'sh7fff);
    add(dlf_pkg::REQ_WEIGHT, 0, 1, 16'sh8000);
    add(dlf_pkg::REQ_WEIGHT, 1, 0, 16'sh8000);
    add(dlf_pkg::REQ_WEIGHT, 1, 1, 16'sh0100);
    add(dlf_pkg::REQ_BIAS, 0, 0, 16'sh7fff);
    add(dlf_pkg::REQ_BIAS, 1, 0, 16'sh8000);
    add(dlf_pkg::REQ_WEIGHT, 31, 31, 16'sh0001);
    add(dlf_pkg::REQ_BIAS, 31, 31, 16'shffff);
    add(REQ_UNUSED, 31, 31, 16'shffff);
    add(dlf_pkg::REQ_ELEM, 0, 31, 16'shffff);
    add(dlf_pkg::REQ_ELEM, 0, 0, 16'sh7fff);
    add(dlf_pkg::REQ_ELEM, 0, 0, 16'sh8000);
    add(dlf_pkg::REQ_ELEM, 31, 1, 16'sh0100);
    add(dlf_pkg::REQ_ELEM, 0, 1, 16'sh8000);
    play_burst();

    // Sigmoid clamp edges and table ends with unit weight and zero bias
    set_config(dlf_pkg::ACT_SIG, 6'd1, 6'd1);
    add(dlf_pkg::REQ_WEIGHT, 0, 0, 16'sh0100);
    add(dlf_pkg::REQ_BIAS, 0, 0, 16'sh0000);
    for (k = 0; k < 8; k++) add(dlf_pkg::REQ_ELEM, 0, 0, probe[k]);
    play_burst();

    // Random vectors over several settings, count clamping included
    run_phase(dlf_pkg::ACT_RELU, 6'd0, 6'd63, 30);
    run_phase(ACT_UNUSED, 6'd63, 6'd1, 30);
    run_phase(dlf_pkg::ACT_SIG, 6'd3, 6'd4, 50);
    run_phase(dlf_pkg::ACT_NONE, 6'd32, 6'd32, 50);
    calm = 1'b1;
    run_phase(dlf_pkg::ACT_SIG, 6'd32, 6'd32, 40);
    calm = 1'b0;
    run_phase(dlf_pkg::ACT_RELU, 6'd1, 6'd32, 30);
    run_phase(dlf_pkg::ACT_NONE, 6'd5, 6'd7, 40);
    for (k = 0; k < 3; k++)
      run_phase(2'($urandom_range(3)), 6'($urandom_range(40)), 6'($urandom_range(40)), 20);

    // Accumulator wrap: 2^30 per element until the sum crosses 2^39
    set_config(dlf_pkg::ACT_NONE, 6'd2, 6'd1);
    add(dlf_pkg::REQ_WEIGHT, 0, 0, 16'sh8000);
    add(dlf_pkg::REQ_WEIGHT, 0, 1, 16'sh0000);
    add(dlf_pkg::REQ_BIAS, 0, 0, 16'sh0000);
    for (k = 0; k < OVERFLOW_ELEMS; k++) add(dlf_pkg::REQ_ELEM, 0, 0, 16'sh8000);
    add(dlf_pkg::REQ_ELEM, 0, 1, 16'sh0000);
    play_burst();

    settle();
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
